FILE: hdl/joint_histogram_log_render_assert.svh
// Assertion macros shared by the histogram RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef JOINT_HISTOGRAM_LOG_RENDER_ASSERT_SVH
`define JOINT_HISTOGRAM_LOG_RENDER_ASSERT_SVH

// Same-cycle implication
`define JHLR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define JHLR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/jhlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jhlr_pkg;

    // Default geometry
    localparam int DEF_MAX_X_BINS = 256;
    localparam int DEF_MAX_Y_BINS = 256;
    localparam int DEF_COUNT_BITS = 32;

    // Port widths fixed by the interface
    localparam int COUNT_PORT_W = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 9;

    // Item function codes
    localparam logic [1:0] FUNC_ACCUM = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_BINS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_BINS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RENDER_MODE = 3'd4;

    // Register reset value and opacity levels
    localparam logic [8:0] BINS_RESET   = 9'd256;
    localparam logic [7:0] OPACITY_FULL = 8'd255;
    localparam logic [7:0] OPACITY_NONE = 8'd0;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_READ,
        ST_LOG,
        ST_LOG_END,
        ST_DIV,
        ST_DIV_END,
        ST_DONE
    } state_t;

    // Fractional log2 table: 12 fraction bits of log2((256+f)/256)
    typedef logic [11:0] log_table_t [256];

    function automatic log_table_t build_log_table();
        log_table_t  t;
        logic [63:0] m;
        logic [11:0] r;
        for (int f = 0; f < 256; f++)
        begin
            m = 64'(256 + f) << 22;
            r = '0;
            for (int i = 0; i < 12; i++)
            begin
                m = (m * m) >> 30;
                r = r << 1;
                if (m >= 64'h0000_0000_8000_0000)
                begin
                    r[0] = 1'b1;
                    m    = m >> 1;
                end
            end
            t[f] = r;
        end
        return t;
    endfunction

    localparam log_table_t LOG_TABLE = build_log_table();

endpackage

`default_nettype wire

FILE: hdl/joint_histogram_log_render.sv
`timescale 1ns / 1ps
`default_nettype none
`include "joint_histogram_log_render_assert.svh"

// 2D joint histogram with log-scaled opacity readout. Bin counts live in one
// synchronous RAM of MAX_X_BINS*MAX_Y_BINS words; the bin at column x, row y
// sits at y*MAX_X_BINS + x. One item is worked at a time through a sequencer
// around that RAM. An accumulate reads, increments and writes back the bin;
// an out-of-grid or unused item goes straight to the result, and a read in
// binary mode or of an empty bin ends once the word is read. A log-mode read
// runs two logs of S normalize steps each, where S = clog2(COUNT_BITS), and a
// restoring divide of D = clog2(COUNT_BITS) + 20 quotient bits; with a peak
// of one it ends after the second log. A clear item sweeps the RAM one word
// per cycle, and the same sweep runs once after reset before the first item
// is taken; configuration writes are taken at any time. The output register
// holds a finished result so the next item can start while it waits for
// transfer; a result that finds the output register still full waits in
// place, and no new item is taken while it waits.

module joint_histogram_log_render #(
    parameter int MAX_X_BINS = jhlr_pkg::DEF_MAX_X_BINS,
    parameter int MAX_Y_BINS = jhlr_pkg::DEF_MAX_Y_BINS,
    parameter int COUNT_BITS = jhlr_pkg::DEF_COUNT_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Configuration writes
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [jhlr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [jhlr_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Input items
    input  wire logic                                in_valid,
    output      logic                                in_stall,
    input  wire logic [1:0]                          func,
    input  wire logic [7:0]                          x_value,
    input  wire logic [7:0]                          y_value,
    input  wire logic [7:0]                          read_x,
    input  wire logic [7:0]                          read_y,

    // Results
    output      logic                                out_valid,
    input  wire logic                                out_stall,
    output      logic [jhlr_pkg::COUNT_PORT_W-1:0]   bin_count,
    output      logic [7:0]                          opacity,
    output      logic [jhlr_pkg::COUNT_PORT_W-1:0]   peak_count,
    output      logic                                out_of_range
);

    localparam int DEPTH  = MAX_X_BINS * MAX_Y_BINS;
    localparam int AW     = $clog2(DEPTH);
    localparam int S      = $clog2(COUNT_BITS);
    localparam int PW     = S;
    localparam int SW     = $clog2(S);
    localparam int LOG_W  = PW + 12;
    localparam int DW     = LOG_W + 8;
    localparam int DCW    = $clog2(DW);
    localparam int CPW    = jhlr_pkg::COUNT_PORT_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Control state
    jhlr_pkg::state_t        state_reg, state_next;
    logic [AW-1:0]           clr_ptr_reg, clr_ptr_next;
    logic                    clr_item_reg, clr_item_next;
    logic [COUNT_BITS-1:0]   peak_reg, peak_next;
    logic                    out_valid_reg, out_valid_next;

    // Configuration registers
    logic [7:0]              x_offset_reg;
    logic [7:0]              y_offset_reg;
    logic [8:0]              x_bins_reg;
    logic [8:0]              y_bins_reg;
    logic                    render_mode_reg;

    // Working registers
    logic [AW-1:0]           addr_reg, addr_next;
    logic [COUNT_BITS-1:0]   norm_reg, norm_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [SW-1:0]           step_reg, step_next;
    logic                    log_peak_reg, log_peak_next;
    logic [LOG_W-1:0]        lc_reg, lc_next;
    logic [LOG_W-1:0]        lp_reg, lp_next;
    logic [LOG_W-1:0]        rem_reg, rem_next;
    logic [DW-1:0]           dvd_reg, dvd_next;
    logic [DW-1:0]           quo_reg, quo_next;
    logic [DCW-1:0]          div_cnt_reg, div_cnt_next;
    logic [COUNT_BITS-1:0]   res_count_reg, res_count_next;
    logic [7:0]              res_opa_reg, res_opa_next;
    logic                    res_oor_reg, res_oor_next;

    // Output register
    logic [CPW-1:0]          bin_count_reg, bin_count_next;
    logic [7:0]              opacity_reg, opacity_next;
    logic [CPW-1:0]          peak_count_reg, peak_count_next;
    logic                    out_of_range_reg, out_of_range_next;

    // RAM port
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [COUNT_BITS-1:0]   ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [COUNT_BITS-1:0]   ram_rdata;

    // Datapath helpers
    logic [8:0]              x_lim;
    logic [8:0]              y_lim;
    logic [7:0]              acc_px;
    logic [7:0]              acc_py;
    logic                    acc_oor;
    logic                    rd_oor;
    logic [AW-1:0]           acc_addr;
    logic [AW-1:0]           rd_addr;
    logic                    out_free;
    logic [COUNT_BITS-1:0]   acc_inc;
    logic [PW-1:0]           log_k;
    logic [COUNT_BITS-1:0]   top_mask;
    logic [COUNT_BITS+7:0]   norm_ext;
    logic [7:0]              log_f;
    logic [LOG_W-1:0]        log_val;
    logic [LOG_W:0]          div_trial;
    logic                    div_ge;

    jhlr_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Grid bounds and bin addresses
    assign x_lim    = (x_bins_reg < 9'(MAX_X_BINS)) ? x_bins_reg : 9'(MAX_X_BINS);
    assign y_lim    = (y_bins_reg < 9'(MAX_Y_BINS)) ? y_bins_reg : 9'(MAX_Y_BINS);
    assign acc_px   = x_value - x_offset_reg;
    assign acc_py   = y_value - y_offset_reg;
    assign acc_oor  = ({1'b0, acc_px} >= x_lim) || ({1'b0, acc_py} >= y_lim);
    assign rd_oor   = ({1'b0, read_x} >= x_lim) || ({1'b0, read_y} >= y_lim);
    assign acc_addr = AW'(32'(acc_py) * 32'(MAX_X_BINS) + 32'(acc_px));
    assign rd_addr  = AW'(32'(read_y) * 32'(MAX_X_BINS) + 32'(read_x));
    assign ram_raddr = (func == jhlr_pkg::FUNC_READ) ? rd_addr : acc_addr;

    // Saturating increment of the stored count
    assign acc_inc = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

    // Leading-one normalize: one binary-search step per cycle
    assign log_k    = PW'(1) << (SW'(S - 1) - step_reg);
    assign top_mask = ~(COUNT_MAX >> log_k);
    assign norm_ext = {norm_reg, 8'h00};
    assign log_f    = norm_ext[COUNT_BITS+6 -: 8];
    assign log_val  = norm_reg[COUNT_BITS-1] ? {pos_reg, jhlr_pkg::LOG_TABLE[log_f]} : '0;

    // Restoring divider step
    assign div_trial = {rem_reg, dvd_reg[DW-1]};
    assign div_ge    = div_trial >= {1'b0, lp_reg};

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        clr_ptr_next      = clr_ptr_reg;
        clr_item_next     = clr_item_reg;
        peak_next         = peak_reg;
        out_valid_next    = out_valid_reg;
        addr_next         = addr_reg;
        norm_next         = norm_reg;
        pos_next          = pos_reg;
        step_next         = step_reg;
        log_peak_next     = log_peak_reg;
        lc_next           = lc_reg;
        lp_next           = lp_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        quo_next          = quo_reg;
        div_cnt_next      = div_cnt_reg;
        res_count_next    = res_count_reg;
        res_opa_next      = res_opa_reg;
        res_oor_next      = res_oor_reg;
        bin_count_next    = bin_count_reg;
        opacity_next      = opacity_reg;
        peak_count_next   = peak_count_reg;
        out_of_range_next = out_of_range_reg;
        ram_we            = 1'b0;
        ram_waddr         = addr_reg;
        ram_wdata         = '0;

        // Output transfer frees the register
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            jhlr_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_ptr_reg;
                if (clr_ptr_reg == AW'(DEPTH - 1))
                begin
                    clr_ptr_next = '0;
                    if (clr_item_reg)
                    begin
                        clr_item_next  = 1'b0;
                        res_count_next = '0;
                        res_opa_next   = jhlr_pkg::OPACITY_NONE;
                        res_oor_next   = 1'b0;
                        state_next     = jhlr_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = jhlr_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    clr_ptr_next = clr_ptr_reg + 1'b1;
                end
            end

            jhlr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_count_next = '0;
                    res_opa_next   = jhlr_pkg::OPACITY_NONE;
                    res_oor_next   = 1'b0;
                    unique case (func)
                        jhlr_pkg::FUNC_ACCUM:
                        begin
                            addr_next = acc_addr;
                            if (acc_oor)
                            begin
                                res_oor_next = 1'b1;
                                state_next   = jhlr_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = jhlr_pkg::ST_ACC;
                            end
                        end
                        jhlr_pkg::FUNC_READ:
                        begin
                            addr_next = rd_addr;
                            if (rd_oor)
                            begin
                                res_oor_next = 1'b1;
                                state_next   = jhlr_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = jhlr_pkg::ST_READ;
                            end
                        end
                        jhlr_pkg::FUNC_CLEAR:
                        begin
                            peak_next     = '0;
                            clr_item_next = 1'b1;
                            state_next    = jhlr_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = jhlr_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // Read data is back: increment and write to the same word
            jhlr_pkg::ST_ACC:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = acc_inc;
                if (acc_inc > peak_reg)
                begin
                    peak_next = acc_inc;
                end
                res_count_next = acc_inc;
                state_next     = jhlr_pkg::ST_DONE;
            end

            jhlr_pkg::ST_READ:
            begin
                res_count_next = ram_rdata;
                if (ram_rdata == '0)
                begin
                    state_next = jhlr_pkg::ST_DONE;
                end
                else if (render_mode_reg)
                begin
                    res_opa_next = jhlr_pkg::OPACITY_FULL;
                    state_next   = jhlr_pkg::ST_DONE;
                end
                else
                begin
                    norm_next     = ram_rdata;
                    pos_next      = PW'(COUNT_BITS - 1);
                    step_next     = '0;
                    log_peak_next = 1'b0;
                    state_next    = jhlr_pkg::ST_LOG;
                end
            end

            jhlr_pkg::ST_LOG:
            begin
                if ((norm_reg & top_mask) == '0)
                begin
                    norm_next = norm_reg << log_k;
                    pos_next  = pos_reg - log_k;
                end
                if (step_reg == SW'(S - 1))
                begin
                    state_next = jhlr_pkg::ST_LOG_END;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            jhlr_pkg::ST_LOG_END:
            begin
                if (!log_peak_reg)
                begin
                    // Count done; now the peak
                    lc_next       = log_val;
                    norm_next     = peak_reg;
                    pos_next      = PW'(COUNT_BITS - 1);
                    step_next     = '0;
                    log_peak_next = 1'b1;
                    state_next    = jhlr_pkg::ST_LOG;
                end
                else if (log_val == '0)
                begin
                    // Peak of one
                    res_opa_next = jhlr_pkg::OPACITY_FULL;
                    state_next   = jhlr_pkg::ST_DONE;
                end
                else
                begin
                    lp_next      = log_val;
                    dvd_next     = (DW'(lc_reg) << 8) - DW'(lc_reg);
                    rem_next     = '0;
                    quo_next     = '0;
                    div_cnt_next = '0;
                    state_next   = jhlr_pkg::ST_DIV;
                end
            end

            jhlr_pkg::ST_DIV:
            begin
                rem_next = div_ge ? LOG_W'(div_trial - {1'b0, lp_reg}) : LOG_W'(div_trial);
                dvd_next = dvd_reg << 1;
                quo_next = {quo_reg[DW-2:0], div_ge};
                if (div_cnt_reg == DCW'(DW - 1))
                begin
                    state_next = jhlr_pkg::ST_DIV_END;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end

            jhlr_pkg::ST_DIV_END:
            begin
                res_opa_next = (quo_reg > DW'(255)) ? jhlr_pkg::OPACITY_FULL : quo_reg[7:0];
                state_next   = jhlr_pkg::ST_DONE;
            end

            // Hand the result to the output register
            jhlr_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    bin_count_next    = CPW'(res_count_reg);
                    opacity_next      = res_opa_reg;
                    peak_count_next   = CPW'(peak_reg);
                    out_of_range_next = res_oor_reg;
                    out_valid_next    = 1'b1;
                    state_next        = jhlr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = jhlr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jhlr_pkg::ST_CLEAR;
            clr_ptr_reg   <= '0;
            clr_item_reg  <= 1'b0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            log_peak_reg  <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            clr_item_reg  <= clr_item_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            log_peak_reg  <= log_peak_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg    <= '0;
            y_offset_reg    <= '0;
            x_bins_reg      <= jhlr_pkg::BINS_RESET;
            y_bins_reg      <= jhlr_pkg::BINS_RESET;
            render_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                jhlr_pkg::CFG_X_OFFSET:    x_offset_reg    <= cfg_data[7:0];
                jhlr_pkg::CFG_Y_OFFSET:    y_offset_reg    <= cfg_data[7:0];
                jhlr_pkg::CFG_X_BINS:      x_bins_reg      <= cfg_data;
                jhlr_pkg::CFG_Y_BINS:      y_bins_reg      <= cfg_data;
                jhlr_pkg::CFG_RENDER_MODE: render_mode_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg         <= addr_next;
        norm_reg         <= norm_next;
        pos_reg          <= pos_next;
        lc_reg           <= lc_next;
        lp_reg           <= lp_next;
        rem_reg          <= rem_next;
        dvd_reg          <= dvd_next;
        quo_reg          <= quo_next;
        res_count_reg    <= res_count_next;
        res_opa_reg      <= res_opa_next;
        res_oor_reg      <= res_oor_next;
        bin_count_reg    <= bin_count_next;
        opacity_reg      <= opacity_next;
        peak_count_reg   <= peak_count_next;
        out_of_range_reg <= out_of_range_next;
    end

    assign cfg_ready    = 1'b1;
    assign in_stall     = (state_reg != jhlr_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign bin_count    = bin_count_reg;
    assign opacity      = opacity_reg;
    assign peak_count   = peak_count_reg;
    assign out_of_range = out_of_range_reg;

    // Checks
    `JHLR_ASSERT_IMP(a_count_within_peak, out_valid_reg, bin_count_reg <= peak_count_reg, "result count above peak")
    `JHLR_ASSERT_IMP(a_opacity_needs_count, out_valid_reg && (opacity_reg != 8'h00), bin_count_reg != '0, "opacity on empty bin")
    `JHLR_ASSERT_NXT(a_peak_covers_write, state_reg == jhlr_pkg::ST_ACC, peak_reg >= $past(ram_wdata), "peak below written count")
    `JHLR_ASSERT_IMP(a_no_write_on_accept, in_valid && !in_stall, !ram_we, "RAM write while taking an item")
    `JHLR_ASSERT_IMP(a_sweep_parked, state_reg == jhlr_pkg::ST_IDLE, clr_ptr_reg == '0, "clear pointer not parked")

endmodule

`default_nettype wire

FILE: hdl/jhlr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module jhlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
